// ===== rtl/core/pss_pkg.sv =====
// Package for the program stream packet scanner.
// Holds parse phase codes, event kinds, the event record type and header tables.
// No dependencies.
package pss_pkg;

    localparam logic [3:0] PH_HUNT      = 4'd0;
    localparam logic [3:0] PH_ID        = 4'd1;
    localparam logic [3:0] PH_PACK_B4   = 4'd2;
    localparam logic [3:0] PH_PACK_B13  = 4'd3;
    localparam logic [3:0] PH_LEN_HI    = 4'd4;
    localparam logic [3:0] PH_LEN_LO    = 4'd5;
    localparam logic [3:0] PH_SKIP      = 4'd6;
    localparam logic [3:0] PH_AV_FIRST  = 4'd7;
    localparam logic [3:0] PH_PS_FIRST  = 4'd8;
    localparam logic [3:0] PH_PS_HDRLEN = 4'd9;
    localparam logic [3:0] PH_PS_STUFF  = 4'd10;
    localparam logic [3:0] PH_PS_TABLE  = 4'd11;
    localparam logic [3:0] PH_PS_SUBID  = 4'd12;
    localparam logic [3:0] PH_STOPPED   = 4'd13;

    localparam logic [2:0] EV_PACK    = 3'd0;
    localparam logic [2:0] EV_PES     = 3'd1;
    localparam logic [2:0] EV_SKIPPED = 3'd2;
    localparam logic [2:0] EV_END     = 3'd3;
    localparam logic [2:0] EV_ES      = 3'd4;
    localparam logic [2:0] EV_WEIRD   = 3'd5;
    localparam logic [2:0] EV_MISSING = 3'd6;

    localparam logic [7:0] ID_END  = 8'hb9;
    localparam logic [7:0] ID_PACK = 8'hba;
    localparam logic [7:0] ID_PS1  = 8'hbd;
    localparam logic [7:0] ID_SEQ  = 8'hb3;

    // Classified event from the front, counted and completed by the back
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  id;
        logic [31:0] start;
        logic [15:0] len;
        logic        m2;
        logic        mis;
        logic        count;     // bump packet count for id
        logic        sub_ok;    // check sub-id for a new track
        logic [7:0]  sub;
    } ev_t;

    // Extra header bytes after an MPEG-1 header code, zero for invalid codes
    function automatic logic [3:0] mpeg1_extra(input logic [3:0] code);
        logic [3:0] r;
        begin
            unique case (code)
                4'd0:    r = 4'd1;
                4'd2:    r = 4'd5;
                4'd3:    r = 4'd10;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/pss_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module pss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/pss_front.sv =====
// Front parser: tracks the start code window and packet phases, emits event records.
// Depends on pss_pkg.
module pss_front
    import pss_pkg::*;
#(
    parameter int STUFFING_LIMIT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] align_log2,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       ev_stall,
    output logic       ev_valid,
    output ev_t        ev
);
    localparam int SCW = $clog2(STUFFING_LIMIT + 1);

    logic [3:0]     phase_reg, phase_next;
    logic [23:0]    win_reg, win_next;
    logic [31:0]    pos_reg;
    logic [8:0]     hidx_reg, hidx_next;
    logic [16:0]    skip_reg, skip_next;
    logic [7:0]     id_reg, id_next;
    logic [15:0]    len_reg, len_next;
    logic [31:0]    pstart_reg, pstart_next;
    logic [31:0]    lastpack_reg, lastpack_next;
    logic [SCW-1:0] stuff_reg, stuff_next;
    logic [9:0]     goal_reg, goal_next;
    logic           warned_reg, warned_next;
    logic           m2_reg, m2_next;

    logic        emit;
    ev_t         e;
    logic [31:0] inc, amask;
    logic [3:0]  extra;
    logic [8:0]  hi1;
    logic [3:0]  bphase;

    // Next-state parse logic for one byte
    always_comb
    begin
        phase_next = phase_reg; win_next = win_reg; hidx_next = hidx_reg;
        skip_next = skip_reg; id_next = id_reg; len_next = len_reg;
        pstart_next = pstart_reg; lastpack_next = lastpack_reg;
        stuff_next = stuff_reg; goal_next = goal_reg;
        warned_next = warned_reg; m2_next = m2_reg;
        emit = 1'b0; bphase = phase_reg;
        e = '0;
        e.id = id_reg; e.start = pstart_reg; e.len = len_reg;
        inc = pstart_reg - lastpack_reg;
        amask = (32'd1 << align_log2) - 32'd1;
        extra = mpeg1_extra(data_byte[7:4]);
        hi1 = (hidx_reg < 9'd511) ? hidx_reg + 9'd1 : hidx_reg;
        unique case (phase_reg)
            PH_STOPPED: ;
            PH_HUNT:
            begin
                win_next = {win_reg[15:0], data_byte};
                if (hidx_reg < 9'd3) hidx_next = hidx_reg + 9'd1;
                if (win_next == 24'h000001)
                begin
                    pstart_next = pos_reg - 32'd2;
                    phase_next = PH_ID;
                end
                else if (hidx_next >= 9'd3 && !warned_reg)
                begin
                    warned_next = 1'b1;
                    emit = 1'b1;
                    e.kind = EV_MISSING; e.id = 8'd0; e.start = pos_reg - 32'd2;
                    e.len = 16'd0;
                end
            end
            PH_ID:
            begin
                id_next = data_byte; hidx_next = 9'd3; m2_next = 1'b0;
                e.id = data_byte; e.len = 16'd0;
                if (data_byte == ID_END)
                begin
                    phase_next = PH_STOPPED; emit = 1'b1; e.kind = EV_END;
                end
                else if (data_byte == ID_PACK)
                begin
                    phase_next = PH_PACK_B4;
                end
                else if (data_byte == ID_SEQ || data_byte < ID_END)
                begin
                    phase_next = PH_STOPPED; emit = 1'b1; e.kind = EV_ES;
                end
                else
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_PACK_B4:
            begin
                hidx_next = 9'd4; lastpack_next = pstart_reg;
                emit = 1'b1; e.count = 1'b1; e.id = ID_PACK; e.len = 16'd0;
                e.mis = (inc != 32'd0) && ((inc & amask) != 32'd0);
                e.kind = EV_PACK;
                if (data_byte[7:6] == 2'b01)
                begin
                    e.m2 = 1'b1; phase_next = PH_PACK_B13;
                end
                else if (data_byte[7:4] == 4'h2)
                begin
                    skip_next = 17'd7; phase_next = PH_SKIP;
                end
                else
                begin
                    e.kind = EV_WEIRD; phase_next = PH_STOPPED;
                end
            end
            PH_PACK_B13:
            begin
                hidx_next = hidx_reg + 9'd1;
                if (hidx_next >= 9'd13)
                begin
                    skip_next = {14'd0, data_byte[2:0]};
                    if (data_byte[2:0] == 3'd0)
                    begin
                        phase_next = PH_HUNT; win_next = '1; hidx_next = '0;
                    end
                    else phase_next = PH_SKIP;
                end
            end
            PH_LEN_HI:
            begin
                hidx_next = 9'd4; len_next = {data_byte, 8'd0}; phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                hidx_next = 9'd5;
                len_next = {len_reg[15:8], data_byte};
                skip_next = {1'b0, len_next};
                e.len = len_next;
                if (id_reg == 8'hbc || id_reg > 8'he9)
                begin
                    emit = 1'b1; e.kind = EV_SKIPPED;
                    if (len_next == 16'd0)
                    begin
                        phase_next = PH_HUNT; win_next = '1; hidx_next = '0;
                    end
                    else phase_next = PH_SKIP;
                end
                else if (id_reg == 8'hbb || id_reg == 8'hbe || id_reg == 8'hbf
                         || len_next == 16'd0)
                begin
                    emit = 1'b1; e.kind = EV_PES; e.count = 1'b1;
                    if (len_next == 16'd0)
                    begin
                        phase_next = PH_HUNT; win_next = '1; hidx_next = '0;
                    end
                    else phase_next = PH_SKIP;
                end
                else
                begin
                    phase_next = (id_reg == ID_PS1) ? PH_PS_FIRST : PH_AV_FIRST;
                end
            end
            default:
            begin
                // Packet body byte
                hidx_next = hi1;
                if (skip_reg != 17'd0) skip_next = skip_reg - 17'd1;
                e.kind = EV_PES; e.count = 1'b1;
                if (phase_reg == PH_PS_FIRST)
                begin
                    if (data_byte[7:6] == 2'b10)
                    begin
                        m2_next = 1'b1; phase_next = PH_PS_HDRLEN;
                    end
                    else
                    begin
                        m2_next = 1'b0; stuff_next = '0; bphase = PH_PS_STUFF;
                        phase_next = PH_PS_STUFF;
                    end
                end
                priority case (bphase)
                    PH_AV_FIRST:
                    begin
                        emit = 1'b1; e.m2 = (data_byte[7:6] == 2'b10);
                        phase_next = PH_SKIP;
                    end
                    PH_PS_STUFF:
                    begin
                        if (data_byte == 8'hff)
                        begin
                            if (32'(stuff_next) >= STUFFING_LIMIT)
                            begin
                                emit = 1'b1; phase_next = PH_SKIP;
                            end
                            else stuff_next = stuff_next + SCW'(1);
                        end
                        else if (data_byte[7:6] == 2'b01)
                        begin
                            goal_next = {1'b0, hi1} + 10'd2; phase_next = PH_PS_TABLE;
                        end
                        else if (extra == 4'd0)
                        begin
                            emit = 1'b1; phase_next = PH_SKIP;
                        end
                        else
                        begin
                            goal_next = {1'b0, hi1} + {6'd0, extra};
                            phase_next = PH_PS_SUBID;
                        end
                    end
                    PH_PS_HDRLEN:
                    begin
                        if (hi1 == 9'd8)
                        begin
                            goal_next = 10'd9 + {2'd0, data_byte};
                            phase_next = PH_PS_SUBID;
                        end
                    end
                    PH_PS_TABLE:
                    begin
                        if ({1'b0, hi1} == goal_reg)
                        begin
                            if (extra == 4'd0)
                            begin
                                emit = 1'b1; phase_next = PH_SKIP;
                            end
                            else
                            begin
                                goal_next = {1'b0, hi1} + {6'd0, extra};
                                phase_next = PH_PS_SUBID;
                            end
                        end
                    end
                    PH_PS_SUBID:
                    begin
                        if ({1'b0, hi1} == goal_reg)
                        begin
                            emit = 1'b1; e.m2 = m2_reg; e.sub_ok = 1'b1;
                            e.sub = data_byte; phase_next = PH_SKIP;
                        end
                    end
                    default: ;
                endcase
                if (skip_next == 17'd0)
                begin
                    if (!emit && phase_next != PH_SKIP)
                    begin
                        emit = 1'b1; e.m2 = m2_next;
                    end
                    phase_next = PH_HUNT; win_next = '1; hidx_next = '0;
                end
            end
        endcase
    end

    // Advance parser state on each accepted byte; hold a pending event while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT; win_reg <= '1; pos_reg <= '0; hidx_reg <= '0;
            skip_reg <= '0; id_reg <= '0; len_reg <= '0; pstart_reg <= '0;
            lastpack_reg <= '0; stuff_reg <= '0; goal_reg <= '0;
            warned_reg <= 1'b0; m2_reg <= 1'b0; ev_valid <= 1'b0;
        end
        else
        begin
            if (in_fire) ev_valid <= emit;
            else ev_valid <= ev_valid && ev_stall;
            if (in_fire)
            begin
                phase_reg <= phase_next; win_reg <= win_next; pos_reg <= pos_reg + 32'd1;
                hidx_reg <= hidx_next; skip_reg <= skip_next; id_reg <= id_next;
                len_reg <= len_next; pstart_reg <= pstart_next;
                lastpack_reg <= lastpack_next; stuff_reg <= stuff_next;
                goal_reg <= goal_next; warned_reg <= warned_next; m2_reg <= m2_next;
            end
        end
    end

    // Hold the event record
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ev <= e;
        end
    end
endmodule

// ===== rtl/core/pss_back.sv =====
// Back end: packet counts in RAM, audio track flags, output register.
// Depends on pss_pkg and pss_ram.
module pss_back
    import pss_pkg::*;
#(
    parameter int AUDIO_TRACKS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clr_we,
    input  logic [7:0]  clr_addr,
    input  logic        ev_valid,
    input  ev_t         ev,
    output logic        ev_stall,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  stream_id,
    output logic [31:0] start_offset,
    output logic [15:0] payload_length,
    output logic        mpeg2_syntax,
    output logic        pack_misaligned,
    output logic [31:0] packets_seen,
    output logic        first_of_stream,
    output logic        new_audio_track,
    output logic [4:0]  audio_track
);
    localparam int TW = (AUDIO_TRACKS > 1) ? $clog2(AUDIO_TRACKS) : 1;

    // Stage 1 issues the count read; stage 2 updates count and track flags
    logic        s2_reg;
    ev_t         s2_ev_reg;
    logic [31:0] rdata;
    logic [31:0] byp_cnt_reg;
    logic [7:0]  byp_id_reg;
    logic        byp_v_reg;
    logic [AUDIO_TRACKS-1:0] seen_reg;
    logic        adv;
    logic [31:0] cur, nc;
    logic [7:0]  toff;
    logic [TW-1:0] tidx;
    logic        tnew;
    logic [7:0]  raddr;
    logic        ram_we;
    logic [7:0]  ram_waddr;
    logic [31:0] ram_wdata;

    assign adv = !out_valid || !out_stall;
    assign ev_stall = (s2_reg || ev_valid) && !adv;

    // Re-read the stage 2 id while stalled so its count stays current
    assign raddr = adv ? ev.id : s2_ev_reg.id;

    // Clearing pass writes zero ahead of any count update
    assign ram_we    = clr_we || (s2_reg && adv && s2_ev_reg.count);
    assign ram_waddr = clr_we ? clr_addr : s2_ev_reg.id;
    assign ram_wdata = clr_we ? 32'd0 : nc;

    pss_ram #(.WIDTH(32), .DEPTH(256)) u_cnt (
        .clk(clk), .we(ram_we), .waddr(ram_waddr),
        .wdata(ram_wdata), .raddr(raddr), .rdata(rdata));

    // Forward a count written in the previous cycle
    assign cur = (byp_v_reg && byp_id_reg == s2_ev_reg.id) ? byp_cnt_reg : rdata;
    assign nc  = (cur == 32'hffffffff) ? cur : cur + 32'd1;
    assign toff = s2_ev_reg.sub - 8'h80;
    assign tidx = toff[TW-1:0];
    assign tnew = s2_ev_reg.sub_ok && s2_ev_reg.sub[7]
                  && ({1'b0, toff} < 9'(AUDIO_TRACKS))
                  && !seen_reg[tidx];

    // Advance stages and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= 1'b0; out_valid <= 1'b0; byp_v_reg <= 1'b0; seen_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                out_valid <= s2_reg;
                byp_v_reg <= s2_reg && s2_ev_reg.count;
                if (s2_reg && tnew)
                    seen_reg[tidx] <= 1'b1;
            end
            else
            begin
                byp_v_reg <= 1'b0;
            end
            if (adv) s2_reg <= ev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ev_reg <= ev; byp_id_reg <= s2_ev_reg.id; byp_cnt_reg <= nc;
            if (s2_reg)
            begin
                event_kind <= s2_ev_reg.kind; stream_id <= s2_ev_reg.id;
                start_offset <= s2_ev_reg.start; payload_length <= s2_ev_reg.len;
                mpeg2_syntax <= s2_ev_reg.m2; pack_misaligned <= s2_ev_reg.mis;
                packets_seen <= s2_ev_reg.count ? nc : 32'd0;
                first_of_stream <= s2_ev_reg.count && (cur == 32'd0);
                new_audio_track <= tnew; audio_track <= tnew ? toff[4:0] : 5'd0;
            end
        end
    end
endmodule

// ===== rtl/core/program_stream_packet_scanner.sv =====
// Top level of the program stream packet scanner.
// Depends on pss_pkg, pss_front, pss_back, pss_ram.
//
//  channel | signals                        | direction
//  input   | in_valid, in_stall, data_byte  | byte in
//  output  | out_valid, out_stall, fields   | event out
//  config  | cfg_we, cfg_wdata              | alignment write
//
// One byte per cycle while the output drains and no sweep runs. An event passes
// from the edge that accepts its byte through the front event register, stage 2
// with the count RAM read, and the output register.
// Reset clears parser state and track flags; the count RAM is swept to zero after
// reset, all 256 entries, during which in_stall is high.
// in_stall follows out_stall once a stalled event sits in the output register
// and another event waits behind it.
module program_stream_packet_scanner
    import pss_pkg::*;
#(
    parameter int AUDIO_TRACKS   = 32,
    parameter int STUFFING_LIMIT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  stream_id,
    output logic [31:0] start_offset,
    output logic [15:0] payload_length,
    output logic        mpeg2_syntax,
    output logic        pack_misaligned,
    output logic [31:0] packets_seen,
    output logic        first_of_stream,
    output logic        new_audio_track,
    output logic [4:0]  audio_track
);
    logic [4:0] align_reg;
    logic       ev_valid, ev_stall, clr_busy_reg;
    logic [7:0] clr_cnt_reg;
    ev_t        ev, ev_mux;
    logic       ev_valid_mux;

    // Hold the alignment register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) align_reg <= 5'd11;
        else if (cfg_we) align_reg <= cfg_wdata;
    end

    // Sweep the count RAM with zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1; clr_cnt_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 8'd1;
            if (clr_cnt_reg == 8'd255) clr_busy_reg <= 1'b0;
        end
    end

    assign in_stall = clr_busy_reg || ev_stall;

    pss_front #(.STUFFING_LIMIT(STUFFING_LIMIT)) u_front (
        .clk(clk), .rst_n(rst_n), .align_log2(align_reg),
        .in_fire(in_valid && !in_stall), .data_byte(data_byte),
        .ev_stall(ev_stall), .ev_valid(ev_valid), .ev(ev));

    // Block events from the back during the sweep
    always_comb
    begin
        ev_mux = ev; ev_valid_mux = ev_valid;
        if (clr_busy_reg)
        begin
            ev_mux = '0; ev_valid_mux = 1'b0;
        end
    end

    pss_back #(.AUDIO_TRACKS(AUDIO_TRACKS)) u_back (
        .clk(clk), .rst_n(rst_n), .clr_we(clr_busy_reg), .clr_addr(clr_cnt_reg),
        .ev_valid(ev_valid_mux), .ev(ev_mux),
        .ev_stall(ev_stall), .out_valid(out_valid), .out_stall(out_stall),
        .event_kind(event_kind), .stream_id(stream_id), .start_offset(start_offset),
        .payload_length(payload_length), .mpeg2_syntax(mpeg2_syntax),
        .pack_misaligned(pack_misaligned), .packets_seen(packets_seen),
        .first_of_stream(first_of_stream), .new_audio_track(new_audio_track),
        .audio_track(audio_track));
endmodule
